// ----- sv/spq_pkg.sv -----
// Shared types and constants for the sorted priority queue.
package spq_pkg;

  localparam int unsigned DEPTH   = 16;
  localparam int unsigned CNT_W   = $clog2(DEPTH + 1);
  localparam int unsigned COUNT_W = 5;
  localparam int unsigned PRIO_W  = 8;
  localparam int unsigned TAG_W   = 16;
  localparam int unsigned OP_W    = 2;
  localparam int unsigned STAT_W  = 2;

  // Operation selector codes; the unused code acts as a peek
  localparam logic [OP_W-1:0] OP_PUSH = 2'd0;
  localparam logic [OP_W-1:0] OP_POP  = 2'd1;
  localparam logic [OP_W-1:0] OP_PEEK = 2'd2;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef struct packed {
    logic [PRIO_W-1:0] prio;
    logic [TAG_W-1:0]  tag;
  } entry_t;

  // Broadcast from the queue control to every cell
  typedef struct packed {
    logic   push;
    logic   pop;
    entry_t entry;
  } cell_ctrl_t;

endpackage

// ----- sv/spq_in_if.sv -----
// Request channel of the sorted priority queue.
interface spq_in_if
  import spq_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [PRIO_W-1:0] priority_req;
  logic [TAG_W-1:0]  tag;

  modport source (output valid, op, priority_req, tag, input ready);
  modport sink   (input valid, op, priority_req, tag, output ready);
endinterface

// ----- sv/spq_out_if.sv -----
// Result channel of the sorted priority queue.
interface spq_out_if
  import spq_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [STAT_W-1:0]  status;
  logic               front_valid;
  logic [PRIO_W-1:0]  front_priority;
  logic [TAG_W-1:0]   front_tag;
  logic [COUNT_W-1:0] count;

  modport source (output valid, status, front_valid, front_priority, front_tag, count,
                  input ready);
  modport sink   (input valid, status, front_valid, front_priority, front_tag, count,
                  output ready);
endinterface

// ----- sv/spq_cell.sv -----
// One queue slot: holds an entry and shifts toward or away from the front.
module spq_cell
  import spq_pkg::*;
(
  input  logic       clk_i,
  input  cell_ctrl_t ctrl_i,
  input  logic       occ_i,
  input  logic       prev_lt_i,
  input  entry_t     prev_i,
  input  entry_t     next_i,
  output logic       lt_o,
  output entry_t     entry_o,
  output entry_t     entry_d_o
);

  entry_t entry_q, entry_d;

  // Flag a slot the new entry must pass: empty, or strictly lower priority
  assign lt_o = !occ_i || (entry_q.prio < ctrl_i.entry.prio);

  // Push: lower slots shift back, the boundary slot takes the new entry.
  // Pop: every slot advances one place toward the front.
  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.push) begin
      if (lt_o) begin
        entry_d = prev_lt_i ? prev_i : ctrl_i.entry;
      end
    end else if (ctrl_i.pop) begin
      entry_d = next_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o   = entry_q;
  assign entry_d_o = entry_d;

endmodule

// ----- sv/sorted_priority_queue.sv -----
// Sorted priority queue built as a chain of shifting cells, front in cell zero.
// The result of a transaction is registered and presented in the cycle after acceptance.
// Throughput: one transaction per cycle while results are taken; all cells compare and shift in parallel.
// The output register accepts a new request whenever its result is taken that cycle.
// Reset (async, active low) empties the queue and the output register at once.
// Entry contents are not cleared; slots at or above the count are never reported.
module sorted_priority_queue
  import spq_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  spq_in_if.sink    in_i,
  spq_out_if.source out_o
);

  logic [CNT_W-1:0] count_q, count_d;
  logic             out_valid_q;
  status_e          status_q, status_d;
  logic             front_valid_q, front_valid_d;
  entry_t           front_q, front_d;
  logic [CNT_W-1:0] res_count_q;

  logic       accept;
  logic       is_push, is_pop, full, empty;
  cell_ctrl_t ctrl;

  entry_t     cell_q [DEPTH];
  entry_t     cell_d [DEPTH];
  logic       cell_lt [DEPTH];

  // Accept when the result register is free or drains this cycle
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;

  assign is_push = (in_i.op == OP_PUSH);
  assign is_pop  = (in_i.op == OP_POP);
  assign full    = (count_q == CNT_W'(DEPTH));
  assign empty   = (count_q == '0);

  // Broadcast the operation to the cell chain
  assign ctrl.push       = accept && is_push && !full;
  assign ctrl.pop        = accept && is_pop && !empty;
  assign ctrl.entry.prio = in_i.priority_req;
  assign ctrl.entry.tag  = in_i.tag;

  // Build the chain
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    entry_t prev_ent, next_ent;
    logic   prev_lt;
    logic   occ;

    assign occ = (count_q > CNT_W'(i));

    if (i == 0) begin : g_head
      assign prev_ent = ctrl.entry;
      assign prev_lt  = 1'b0;
    end else begin : g_body
      assign prev_ent = cell_q[i-1];
      assign prev_lt  = cell_lt[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign next_ent = cell_q[i];
    end else begin : g_mid
      assign next_ent = cell_q[i+1];
    end

    spq_cell u_cell (
      .clk_i     (clk_i),
      .ctrl_i    (ctrl),
      .occ_i     (occ),
      .prev_lt_i (prev_lt),
      .prev_i    (prev_ent),
      .next_i    (next_ent),
      .lt_o      (cell_lt[i]),
      .entry_o   (cell_q[i]),
      .entry_d_o (cell_d[i])
    );
  end

  // Compute next count and the status of the transaction
  always_comb begin
    count_d  = count_q;
    status_d = ST_OK;
    case (in_i.op)
      OP_PUSH: begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          count_d = count_q + CNT_W'(1);
        end
      end
      OP_POP: begin
        if (empty) begin
          status_d = ST_EMPTY;
        end else begin
          count_d = count_q - CNT_W'(1);
        end
      end
      default: begin
        if (empty) begin
          status_d = ST_EMPTY;
        end
      end
    endcase
  end

  // Report the front after the operation, zeroed when the queue ends empty
  assign front_valid_d = (count_d != '0);
  assign front_d       = front_valid_d ? cell_d[0] : '0;

  // Hold the count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (accept) begin
      count_q <= count_d;
    end
  end

  // Advance or drop the output valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Load the result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q      <= status_d;
      front_valid_q <= front_valid_d;
      front_q       <= front_d;
      res_count_q   <= count_d;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.status         = status_q;
  assign out_o.front_valid    = front_valid_q;
  assign out_o.front_priority = front_q.prio;
  assign out_o.front_tag      = front_q.tag;
  assign out_o.count          = COUNT_W'(res_count_q);

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("queue count exceeds depth");

  a_front_sorted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q >= CNT_W'(2)) |-> (cell_q[0].prio >= cell_q[1].prio))
    else $error("front entries out of priority order");

  a_pop_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.pop |=> (count_q == $past(count_q) - CNT_W'(1)))
    else $error("pop did not decrement count");

  a_result_front: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (front_valid_q == (res_count_q != '0)))
    else $error("front_valid disagrees with reported count");
`endif

endmodule

// ----- tb/sv/sorted_priority_queue_tb.sv -----
// Self-checking testbench for the sorted priority queue with a scoreboard class.
`timescale 1ns / 1ps

module sorted_priority_queue_tb;
  import spq_pkg::*;

  // The unused selector code behaves as a peek
  localparam logic [OP_W-1:0] OP_ALT_PEEK = 2'd3;
  localparam int unsigned     CYCLE_LIMIT = 400000;
  localparam int unsigned     RAND_ITEMS  = 667;

  typedef struct packed {
    status_e            status;
    logic               front_valid;
    logic [PRIO_W-1:0]  front_priority;
    logic [TAG_W-1:0]   front_tag;
    logic [COUNT_W-1:0] count;
  } queue_result_t;

  // Mirror of the queue contents plus the results still owed by the block
  class spq_scoreboard;
    logic [PRIO_W-1:0] slot_prio[DEPTH];
    logic [TAG_W-1:0]  slot_tag[DEPTH];
    int unsigned       held;
    queue_result_t     owed_q[$];
    int unsigned       errors;

    function new();
      held   = 0;
      errors = 0;
    endfunction

    task report(string what);
      $display("[%0t] MISMATCH: %s", $time, what);
      errors++;
    endtask

    function int unsigned pending();
      return owed_q.size();
    endfunction

    // Apply one accepted transaction to the mirror and queue its result
    function void note_request(logic [OP_W-1:0] op, logic [PRIO_W-1:0] pr,
                               logic [TAG_W-1:0] tg);
      queue_result_t r;
      int unsigned   pos;
      int unsigned   k;
      r.status = ST_OK;
      case (op)
        OP_PUSH: begin
          if (held >= DEPTH) begin
            r.status = ST_FULL;
          end else begin
            // Insert below the first entry whose priority is not lower
            pos = 0;
            while (pos < held && slot_prio[pos] < pr) pos++;
            for (k = held; k > pos; k--) begin
              slot_prio[k] = slot_prio[k-1];
              slot_tag[k]  = slot_tag[k-1];
            end
            slot_prio[pos] = pr;
            slot_tag[pos]  = tg;
            held++;
          end
        end
        OP_POP: begin
          if (held == 0) r.status = ST_EMPTY;
          else held--;
        end
        default: begin
          if (held == 0) r.status = ST_EMPTY;
        end
      endcase
      if (held > 0) begin
        r.front_valid    = 1'b1;
        r.front_priority = slot_prio[held-1];
        r.front_tag      = slot_tag[held-1];
      end else begin
        r.front_valid    = 1'b0;
        r.front_priority = '0;
        r.front_tag      = '0;
      end
      r.count = held[COUNT_W-1:0];
      owed_q.push_back(r);
    endfunction

    // Compare one accepted result with the oldest owed one
    task check_result(queue_result_t got);
      queue_result_t want;
      if (owed_q.size() == 0) begin
        report($sformatf("result with no request outstanding (status %0d count %0d)",
                         got.status, got.count));
      end else begin
        want = owed_q.pop_front();
        if (got.status !== want.status)
          report($sformatf("status %0d, expected %0d", got.status, want.status));
        if (got.front_valid !== want.front_valid)
          report($sformatf("front_valid %0b, expected %0b", got.front_valid,
                           want.front_valid));
        if (got.front_priority !== want.front_priority)
          report($sformatf("front_priority %0d, expected %0d", got.front_priority,
                           want.front_priority));
        if (got.front_tag !== want.front_tag)
          report($sformatf("front_tag 0x%04h, expected 0x%04h", got.front_tag,
                           want.front_tag));
        if (got.count !== want.count)
          report($sformatf("count %0d, expected %0d", got.count, want.count));
      end
    endtask
  endclass

  logic clk;
  logic rst_n;
  int unsigned src_idle_pct;
  int unsigned sink_idle_pct;
  int unsigned cycles;

  spq_in_if  in_ch ();
  spq_out_if out_ch ();

  spq_scoreboard sb = new();

  sorted_priority_queue dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Throttle the result channel
  always @(negedge clk) begin
    out_ch.ready = ($urandom_range(0, 99) >= sink_idle_pct);
  end

  // Check results first: a request taken at this edge has its result next cycle
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready)
        sb.check_result('{status:         status_e'(out_ch.status),
                          front_valid:    out_ch.front_valid,
                          front_priority: out_ch.front_priority,
                          front_tag:      out_ch.front_tag,
                          count:          out_ch.count});
      if (in_ch.valid && in_ch.ready)
        sb.note_request(in_ch.op, in_ch.priority_req, in_ch.tag);
    end
  end

  // Send one request; starts and returns at a falling edge
  task automatic send_req(logic [OP_W-1:0] op, logic [PRIO_W-1:0] pr,
                          logic [TAG_W-1:0] tg);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid        = 1'b1;
    in_ch.op           = op;
    in_ch.priority_req = pr;
    in_ch.tag          = tg;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Hold off the sender until every owed result has been taken
  task automatic drain();
    in_ch.valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  // Segments biased toward filling, emptying or churning the queue
  task automatic run_random(int unsigned n);
    int unsigned      left;
    int unsigned      seg;
    int unsigned      push_pct;
    int unsigned      roll;
    bit               narrow;
    logic [OP_W-1:0]  op;
    logic [PRIO_W-1:0] pr;
    left = n;
    while (left > 0) begin
      seg = $urandom_range(8, 48);
      case ($urandom_range(0, 2))
        0:       push_pct = 85;
        1:       push_pct = 15;
        default: push_pct = 50;
      endcase
      narrow = 1'($urandom_range(0, 1));
      while (seg > 0 && left > 0) begin
        roll = $urandom_range(0, 99);
        if (roll < push_pct) op = OP_PUSH;
        else if (roll < push_pct + (100 - push_pct) * 3 / 4) op = OP_POP;
        else if ($urandom_range(0, 1)) op = OP_PEEK;
        else op = OP_ALT_PEEK;
        // Narrow ranges force ties on priority
        if (narrow)
          pr = $urandom_range(0, 1) ? PRIO_W'($urandom_range(0, 3))
                                    : PRIO_W'($urandom_range(252, 255));
        else
          pr = PRIO_W'($urandom_range(0, 255));
        send_req(op, pr, TAG_W'($urandom_range(0, 65535)));
        seg--;
        left--;
      end
    end
  endtask

  initial begin
    rst_n              = 1'b0;
    cycles             = 0;
    src_idle_pct       = 0;
    sink_idle_pct      = 0;
    in_ch.valid        = 1'b0;
    in_ch.op           = OP_PEEK;
    in_ch.priority_req = '0;
    in_ch.tag          = '0;
    out_ch.ready       = 1'b0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Empty queue: pop, peek and the spare selector all refuse
    send_req(OP_POP, 8'd0, 16'd0);
    send_req(OP_PEEK, 8'd0, 16'd0);
    send_req(OP_ALT_PEEK, 8'd0, 16'd0);
    // Extremes and a run of equal priorities
    send_req(OP_PUSH, 8'd255, 16'hFFFF);
    send_req(OP_PUSH, 8'd0, 16'h0000);
    send_req(OP_PUSH, 8'd128, 16'h0001);
    send_req(OP_PUSH, 8'd128, 16'h0002);
    send_req(OP_PUSH, 8'd128, 16'h0003);
    send_req(OP_PEEK, 8'd0, 16'd0);
    send_req(OP_ALT_PEEK, 8'd0, 16'd0);
    // Drain in order, ties leave in arrival order, then pop past empty
    repeat (6) send_req(OP_POP, 8'd0, 16'd0);
    drain();

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          src_idle_pct  = 28;
          sink_idle_pct = 63;
        end
        1: begin
          src_idle_pct  = 63;
          sink_idle_pct = 28;
        end
        default: begin
          src_idle_pct  = 0;
          sink_idle_pct = 0;
        end
      endcase
      run_random(RAND_ITEMS);
      drain();
    end

    // Wait for any stray result, then flag each owed result that never arrived
    repeat (10) @(posedge clk);
    while (sb.pending() != 0) begin
      void'(sb.owed_q.pop_front());
      sb.report("expected result never arrived");
    end
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
